/* rtl/core/complex_arithmetic_unit_defines.svh */
// ---------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// shared macros for the concurrent checks on the unit
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// check sampled on clk, off while in reset
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also active in reset
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cau_pkg.sv */
// ---------------------------------------------------------------------------
// cau_pkg
// shared types and defaults of the complex arithmetic unit
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic dz;
    logic re_neg;
    logic im_neg;
    logic sat;
  } ctl_t;

endpackage

/* rtl/core/complex_arithmetic_unit.sv */
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined signed fixed-point complex alu: add, sub, mul, div, magnitude
// ---------------------------------------------------------------------------
// channel  | ports                                        | handshake
// input    | in_command, in_a_re, in_a_im, in_b_re, in_b_im | start, busy
// result   | out_res_re, out_res_im, out_status           | out_valid strobe
//
// one transaction accepted per cycle while busy is low; busy is high only during reset and
// the cycle after it.
// the path depth is set by the bit-per-stage divider pipeline; every command
// takes the same path length.
// reset clears the valid bits of all stages; results are never held back.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic [1:0]                  out_status
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = 2*WORD_BITS + FRAC_BITS;

  function automatic logic [W:0] clamp(input logic neg, input logic [NB-1:0] mag);
    logic [NB-1:0] lim;
    logic [W-1:0]  m;
    logic          sat;
    lim = neg ? (NB'(1) << (W-1)) : ((NB'(1) << (W-1)) - NB'(1));
    sat = mag > lim;
    m   = sat ? lim[W-1:0] : mag[W-1:0];
    return {sat, neg ? (~m + 1'b1) : m};
  endfunction

  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // stage 1: products and add/sub
  cau_pkg::ctl_t         ctl1_r;
  logic signed [2*W-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [W:0]     as_re_r, as_im_r;
  logic signed [W-1:0]   sqx, sqy;
  cau_pkg::cmd_t         cmd_in;

  assign cmd_in = cau_pkg::cmd_t'(in_command);
  assign sqx    = (cmd_in == cau_pkg::CMD_MAG) ? in_a_re : in_b_re;
  assign sqy    = (cmd_in == cau_pkg::CMD_MAG) ? in_a_im : in_b_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= '{valid: accept, cmd: cmd_in, dz: 1'b0, re_neg: 1'b0,
                  im_neg: 1'b0, sat: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= in_a_re * in_b_re;
    p1_r <= in_a_im * in_b_im;
    p2_r <= in_a_re * in_b_im;
    p3_r <= in_a_im * in_b_re;
    p4_r <= sqx * sqx;
    p5_r <= sqy * sqy;
    if (cmd_in == cau_pkg::CMD_SUB) begin
      as_re_r <= (W+1)'(in_a_re) - (W+1)'(in_b_re);
      as_im_r <= (W+1)'(in_a_im) - (W+1)'(in_b_im);
    end else begin
      as_re_r <= (W+1)'(in_a_re) + (W+1)'(in_b_re);
      as_im_r <= (W+1)'(in_a_im) + (W+1)'(in_b_im);
    end
  end

  // stage 2: cross sums
  cau_pkg::ctl_t         ctl2_r;
  logic signed [2*W:0]   ns_re_r, ns_im_r;
  logic [2*W-1:0]        sq2_r;
  logic signed [W:0]     as_re2_r, as_im2_r;
  logic signed [2*W:0]   e0, e1, e2, e3;

  assign e0 = (2*W+1)'(p0_r);
  assign e1 = (2*W+1)'(p1_r);
  assign e2 = (2*W+1)'(p2_r);
  assign e3 = (2*W+1)'(p3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl1_r.cmd == cau_pkg::CMD_MUL) begin
      ns_re_r <= e0 - e1;
      ns_im_r <= e2 + e3;
    end else begin
      ns_re_r <= e0 + e1;
      ns_im_r <= e3 - e2;
    end
    sq2_r    <= p4_r + p5_r;
    as_re2_r <= as_re_r;
    as_im2_r <= as_im_r;
  end

  // stage 3: sign split, truncation and pre-packing
  cau_pkg::ctl_t  ctl3_nxt, ctl3_r;
  logic [NB-1:0]  num_re_nxt, num_im_nxt, num_re_r, num_im_r;
  logic [W-1:0]   pre_re_nxt, pre_im_nxt, pre_re_r, pre_im_r;
  logic [2*W-1:0] sq3_r;

  always_comb begin
    logic          nre, nim, are, aim;
    logic [2*W:0]  mre, mim;
    logic [W:0]    ame, aim_m, cre, cim;
    nre   = ns_re_r[2*W];
    nim   = ns_im_r[2*W];
    mre   = nre ? -ns_re_r : ns_re_r;
    mim   = nim ? -ns_im_r : ns_im_r;
    are   = as_re2_r[W];
    aim   = as_im2_r[W];
    ame   = are ? -as_re2_r : as_re2_r;
    aim_m = aim ? -as_im2_r : as_im2_r;
    num_re_nxt = NB'(mre[2*W-1:0]) << F;
    num_im_nxt = NB'(mim[2*W-1:0]) << F;
    ctl3_nxt        = ctl2_r;
    ctl3_nxt.re_neg = nre;
    ctl3_nxt.im_neg = nim;
    ctl3_nxt.dz     = (sq2_r == '0);
    case (ctl2_r.cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
        cre = clamp(are, NB'(ame));
        cim = clamp(aim, NB'(aim_m));
      end
      cau_pkg::CMD_MUL: begin
        cre = clamp(nre, NB'(mre[2*W-1:0] >> F));
        cim = clamp(nim, NB'(mim[2*W-1:0] >> F));
      end
      default: begin
        cre = '0;
        cim = '0;
      end
    endcase
    pre_re_nxt   = cre[W-1:0];
    pre_im_nxt   = cim[W-1:0];
    ctl3_nxt.sat = cre[W] | cim[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_re_r <= num_re_nxt;
    num_im_r <= num_im_nxt;
    sq3_r    <= sq2_r;
    pre_re_r <= pre_re_nxt;
    pre_im_r <= pre_im_nxt;
  end

  // iterative stages
  cau_pkg::ctl_t ctl_it;
  logic [NB-1:0] q_re, q_im;
  logic [W-1:0]  root, pre_re_it, pre_im_it;

  cau_iter #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (ctl3_r),
    .in_num_re  (num_re_r),
    .in_num_im  (num_im_r),
    .in_den     (sq3_r),
    .in_sq      (sq3_r),
    .in_pre_re  (pre_re_r),
    .in_pre_im  (pre_im_r),
    .out_ctl    (ctl_it),
    .out_q_re   (q_re),
    .out_q_im   (q_im),
    .out_root   (root),
    .out_pre_re (pre_re_it),
    .out_pre_im (pre_im_it)
  );

  // output stage
  logic                out_valid_r;
  logic signed [W-1:0] out_res_re_r, out_res_im_r, res_re_nxt, res_im_nxt;
  logic [1:0]          out_status_r, status_nxt;

  always_comb begin
    logic [W:0] cre, cim;
    cre = '0;
    cim = '0;
    status_nxt = cau_pkg::ST_OK;
    case (ctl_it.cmd)
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB, cau_pkg::CMD_MUL: begin
        cre = {ctl_it.sat, pre_re_it};
        cim = {1'b0, pre_im_it};
      end
      cau_pkg::CMD_DIV: begin
        if (!ctl_it.dz) begin
          cre = clamp(ctl_it.re_neg, q_re);
          cim = clamp(ctl_it.im_neg, q_im);
        end
      end
      cau_pkg::CMD_MAG: begin
        cre = clamp(1'b0, NB'(root));
      end
      default: begin
        cre = '0;
        cim = '0;
      end
    endcase
    res_re_nxt = cre[W-1:0];
    res_im_nxt = cim[W-1:0];
    if (ctl_it.cmd == cau_pkg::CMD_DIV && ctl_it.dz) begin
      status_nxt = cau_pkg::ST_DZ;
    end else if (cre[W] || cim[W]) begin
      status_nxt = cau_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_it.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_res_re_r <= res_re_nxt;
    out_res_im_r <= res_im_nxt;
    out_status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_res_re_r;
  assign out_res_im = out_res_im_r;
  assign out_status = out_status_r;

endmodule

/* rtl/core/cau_iter.sv */
// ---------------------------------------------------------------------------
// cau_iter
// pipelined restoring dividers (two parts) and square root, one bit per stage
// ---------------------------------------------------------------------------
module cau_iter #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cau_pkg::ctl_t          in_ctl,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0] in_num_re,
  input  logic [2*WORD_BITS+FRAC_BITS-1:0] in_num_im,
  input  logic [2*WORD_BITS-1:0] in_den,
  input  logic [2*WORD_BITS-1:0] in_sq,
  input  logic [WORD_BITS-1:0]   in_pre_re,
  input  logic [WORD_BITS-1:0]   in_pre_im,
  output cau_pkg::ctl_t          out_ctl,
  output logic [2*WORD_BITS+FRAC_BITS-1:0] out_q_re,
  output logic [2*WORD_BITS+FRAC_BITS-1:0] out_q_im,
  output logic [WORD_BITS-1:0]   out_root,
  output logic [WORD_BITS-1:0]   out_pre_re,
  output logic [WORD_BITS-1:0]   out_pre_im
);

  localparam int W  = WORD_BITS;
  localparam int NB = 2*WORD_BITS + FRAC_BITS;

  cau_pkg::ctl_t  ctl_r    [0:NB];
  logic [NB-1:0]  num_re_r [0:NB];
  logic [NB-1:0]  num_im_r [0:NB];
  logic [2*W-1:0] rem_re_r [0:NB];
  logic [2*W-1:0] rem_im_r [0:NB];
  logic [2*W-1:0] den_r    [0:NB];
  logic [2*W-1:0] sq_r     [0:NB];
  logic [W+1:0]   srem_r   [0:NB];
  logic [W-1:0]   root_r   [0:NB];
  logic [W-1:0]   pre_re_r [0:NB];
  logic [W-1:0]   pre_im_r [0:NB];

  assign ctl_r[0]    = in_ctl;
  assign num_re_r[0] = in_num_re;
  assign num_im_r[0] = in_num_im;
  assign rem_re_r[0] = '0;
  assign rem_im_r[0] = '0;
  assign den_r[0]    = in_den;
  assign sq_r[0]     = in_sq;
  assign srem_r[0]   = '0;
  assign root_r[0]   = '0;
  assign pre_re_r[0] = in_pre_re;
  assign pre_im_r[0] = in_pre_im;

  for (genvar k = 0; k < NB; k++) begin : g_stg
    logic [2*W:0] rt_re, rt_im, df_re, df_im;
    logic         ge_re, ge_im;

    assign rt_re = {rem_re_r[k], num_re_r[k][NB-1]};
    assign rt_im = {rem_im_r[k], num_im_r[k][NB-1]};
    assign df_re = rt_re - {1'b0, den_r[k]};
    assign df_im = rt_im - {1'b0, den_r[k]};
    assign ge_re = rt_re >= {1'b0, den_r[k]};
    assign ge_im = rt_im >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      num_re_r[k+1] <= {num_re_r[k][NB-2:0], ge_re};
      num_im_r[k+1] <= {num_im_r[k][NB-2:0], ge_im};
      rem_re_r[k+1] <= ge_re ? df_re[2*W-1:0] : rt_re[2*W-1:0];
      rem_im_r[k+1] <= ge_im ? df_im[2*W-1:0] : rt_im[2*W-1:0];
      den_r[k+1]    <= den_r[k];
      pre_re_r[k+1] <= pre_re_r[k];
      pre_im_r[k+1] <= pre_im_r[k];
    end

    if (k < W) begin : g_sqrt
      logic [W+3:0] remt, trial, sdf;
      logic         sge;

      assign remt  = {srem_r[k], sq_r[k][2*W-1:2*W-2]};
      assign trial = {2'b00, root_r[k], 2'b01};
      assign sdf   = remt - trial;
      assign sge   = remt >= trial;

      always_ff @(posedge clk) begin
        sq_r[k+1]   <= sq_r[k] << 2;
        srem_r[k+1] <= sge ? sdf[W+1:0] : remt[W+1:0];
        root_r[k+1] <= {root_r[k][W-2:0], sge};
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        sq_r[k+1]   <= sq_r[k];
        srem_r[k+1] <= srem_r[k];
        root_r[k+1] <= root_r[k];
      end
    end
  end

  assign out_ctl    = ctl_r[NB];
  assign out_q_re   = num_re_r[NB];
  assign out_q_im   = num_im_r[NB];
  assign out_root   = root_r[NB];
  assign out_pre_re = pre_re_r[NB];
  assign out_pre_im = pre_im_r[NB];

endmodule

/* rtl/core/cau_checker.sv */
// ---------------------------------------------------------------------------
// cau_checker
// port-level checks of the complex arithmetic unit, bound to the top level
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"

module cau_checker #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [2:0]                  in_command,
  input logic signed [WORD_BITS-1:0] in_a_re,
  input logic signed [WORD_BITS-1:0] in_a_im,
  input logic signed [WORD_BITS-1:0] in_b_re,
  input logic signed [WORD_BITS-1:0] in_b_im,
  input logic                        out_valid,
  input logic signed [WORD_BITS-1:0] out_res_re,
  input logic signed [WORD_BITS-1:0] out_res_im,
  input logic [1:0]                  out_status
);

  localparam int LAT = 2*WORD_BITS + FRAC_BITS + 4;

  logic acc_dz, acc_mag;

  assign acc_dz  = start && !busy && (in_command == cau_pkg::CMD_DIV) &&
                   (in_b_re == '0) && (in_b_im == '0);
  assign acc_mag = start && !busy && (in_command == cau_pkg::CMD_MAG);

  `CAU_ASSERT(a_busy_low, $past(rst_n) |-> !busy, "busy high outside reset")
  `CAU_ASSERT(a_out_has_src, out_valid |-> $past(start && !busy, LAT),
              "result without an accepted transaction")
  `CAU_ASSERT(a_dz_zero, (out_valid && out_status == cau_pkg::ST_DZ) |->
              (out_res_re == '0 && out_res_im == '0), "divide by zero with nonzero parts")
  `CAU_ASSERT(a_dz_status, (out_valid && $past(acc_dz, LAT)) |->
              out_status == cau_pkg::ST_DZ, "missing divide by zero status")
  `CAU_ASSERT(a_mag_form, (out_valid && $past(acc_mag, LAT)) |->
              (out_res_im == '0 && !out_res_re[WORD_BITS-1]), "bad magnitude result")

endmodule

bind complex_arithmetic_unit cau_checker #(
  .WORD_BITS (WORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_cau_checker (.*);

/* dv/complex_arithmetic_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// complex_arithmetic_unit_test
// self-checking bench for the complex alu: directed corner operands for each
// command, then random operand streams with varying sender gaps; every
// result is compared field by field against an in-bench fixed-point predictor
// ---------------------------------------------------------------------------
module complex_arithmetic_unit_test;

  localparam int LATENCY = 2 * cau_pkg::WORD_BITS_DEF + cau_pkg::FRAC_BITS_DEF + 4;
  localparam int STALL_LIMIT = 2000;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic signed [31:0] W_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] W_MIN = 32'sh80000000;
  localparam logic signed [31:0] W_ONE = 32'sh00010000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         st;
  } cplx_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_command;
  logic signed [31:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic out_valid;
  logic signed [31:0] out_res_re, out_res_im;
  logic [1:0] out_status;

  cplx_result_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_dz = 0;
  int n_sat = 0;
  int idle_pct = 0;
  int stall_cycles = 0;
  logic accepted_now;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp a sign/magnitude value into the signed 32-bit range
  function automatic logic signed [31:0] clamp_part(input logic neg,
                                                    input logic [127:0] mag,
                                                    inout logic sat);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = mag;
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? -m[31:0] : m[31:0];
  endfunction

  function automatic logic [127:0] abs128(input logic signed [127:0] v);
    return v[127] ? -v : v;
  endfunction

  function automatic cplx_result_t predict_alu(input logic [2:0] cmd,
                                               input logic signed [31:0] ar,
                                               input logic signed [31:0] ai,
                                               input logic signed [31:0] br,
                                               input logic signed [31:0] bi);
    cplx_result_t r;
    logic signed [127:0] xr, xi, sr, si;
    logic signed [127:0] vre, vim;
    logic [127:0] den, sum_sq, root, trial;
    logic sat;
    xr = ar; xi = ai; sr = br; si = bi;
    vre = 0; vim = 0;
    sat = 1'b0;
    r.st = cau_pkg::ST_OK;
    case (cmd)
      cau_pkg::CMD_ADD: begin
        vre = xr + sr;
        vim = xi + si;
      end
      cau_pkg::CMD_SUB: begin
        vre = xr - sr;
        vim = xi - si;
      end
      cau_pkg::CMD_MUL: begin
        vre = xr * sr - xi * si;
        vim = xr * si + xi * sr;
        vre = vre[127] ? -(abs128(vre) >> cau_pkg::FRAC_BITS_DEF)
                       : (vre >> cau_pkg::FRAC_BITS_DEF);
        vim = vim[127] ? -(abs128(vim) >> cau_pkg::FRAC_BITS_DEF)
                       : (vim >> cau_pkg::FRAC_BITS_DEF);
      end
      cau_pkg::CMD_DIV: begin
        den = sr * sr + si * si;
        if (den == 0) begin
          r.st = cau_pkg::ST_DZ;
        end else begin
          vre = xr * sr + xi * si;
          vim = xi * sr - xr * si;
          vre = vre[127] ? -((abs128(vre) << cau_pkg::FRAC_BITS_DEF) / den)
                         : ((abs128(vre) << cau_pkg::FRAC_BITS_DEF) / den);
          vim = vim[127] ? -((abs128(vim) << cau_pkg::FRAC_BITS_DEF) / den)
                         : ((abs128(vim) << cau_pkg::FRAC_BITS_DEF) / den);
        end
      end
      cau_pkg::CMD_MAG: begin
        sum_sq = xr * xr + xi * xi;
        root = 0;
        for (int i = 33; i >= 0; i--) begin
          trial = root | (128'd1 << i);
          if (trial * trial <= sum_sq) root = trial;
        end
        vre = root;
      end
      default: ;
    endcase
    r.re = clamp_part(vre[127], abs128(vre), sat);
    r.im = clamp_part(vim[127], abs128(vim), sat);
    if (r.st == cau_pkg::ST_OK && sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  task automatic send_op(input logic [2:0] cmd, input logic signed [31:0] ar,
                         input logic signed [31:0] ai, input logic signed [31:0] br,
                         input logic signed [31:0] bi);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_command = cmd;
    in_a_re = ar;
    in_a_im = ai;
    in_b_re = br;
    in_b_im = bi;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_alu(cmd, ar, ai, br, bi));
    n_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2: return 32'sd0;
      3, 4: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      5: return $signed({{8{$urandom_range(1) == 1}}, 24'($urandom)});
      default: return $signed(32'($urandom));
    endcase
  endfunction

  function automatic logic [2:0] pick_command();
    int k;
    k = $urandom_range(99);
    if (k < 95) return 3'($urandom_range(cau_pkg::CMD_MAG));
    return 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
  endfunction

  task automatic test_directed();
    send_op(cau_pkg::CMD_ADD, W_MAX, W_MIN, W_ONE, -W_ONE);
    send_op(cau_pkg::CMD_ADD, W_MAX, W_MIN, W_MAX, W_MIN);
    send_op(cau_pkg::CMD_SUB, W_MIN, W_MAX, W_ONE, -W_ONE);
    send_op(cau_pkg::CMD_SUB, 32'sd0, 32'sd0, W_MIN, W_MIN);
    send_op(cau_pkg::CMD_SUB, 32'sd5, -32'sd7, 32'sd3, 32'sd9);
    send_op(cau_pkg::CMD_MUL, W_ONE, W_ONE, W_ONE, -W_ONE);
    send_op(cau_pkg::CMD_MUL, W_MIN, W_MIN, W_MIN, W_MIN);
    send_op(cau_pkg::CMD_MUL, W_MAX, W_MAX, W_MAX, W_MIN);
    send_op(cau_pkg::CMD_MUL, -32'sd3, 32'sd1, 32'sd1, 32'sd1);
    send_op(cau_pkg::CMD_DIV, W_ONE, W_ONE, 32'sd0, 32'sd0);
    send_op(cau_pkg::CMD_DIV, W_MAX, W_MIN, 32'sd0, 32'sd0);
    send_op(cau_pkg::CMD_DIV, W_ONE, 32'sd0, 32'sd0, W_ONE);
    send_op(cau_pkg::CMD_DIV, W_MAX, W_MAX, 32'sd1, 32'sd0);
    send_op(cau_pkg::CMD_DIV, -32'sd7, 32'sd3, W_MIN, W_MAX);
    send_op(cau_pkg::CMD_DIV, W_MIN, W_MIN, W_MIN, W_MIN);
    send_op(cau_pkg::CMD_MAG, 32'sh0003_0000, 32'sh0004_0000, 32'sd0, 32'sd0);
    send_op(cau_pkg::CMD_MAG, W_MIN, W_MIN, W_MAX, W_MAX);
    send_op(cau_pkg::CMD_MAG, W_MAX, 32'sd0, 32'sd0, 32'sd0);
    send_op(cau_pkg::CMD_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_op(CMD_UNUSED_LO, W_MAX, W_MIN, W_ONE, W_ONE);
    send_op(3'd6, W_ONE, W_ONE, W_ONE, W_ONE);
    send_op(CMD_UNUSED_HI, W_MIN, W_MIN, W_MIN, W_MIN);
  endtask

  task automatic test_random(input int count, input int pct);
    logic [2:0] cmd;
    logic signed [31:0] br, bi;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      cmd = pick_command();
      br = pick_operand();
      bi = pick_operand();
      if (cmd == cau_pkg::CMD_DIV && $urandom_range(9) == 0) begin
        br = 0;
        bi = 0;
      end
      send_op(cmd, pick_operand(), pick_operand(), br, bi);
    end
  endtask

  task automatic test_drain_pause();
    idle_pct = 0;
    test_random(40, 0);
    wait_all_results();
    test_random(40, 0);
  endtask

  // result checker
  always @(posedge clk) begin
    cplx_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h status=%0d",
                 $time, out_res_re, out_res_im, out_status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.st == cau_pkg::ST_DZ) n_dz++;
        if (exp_r.st == cau_pkg::ST_SAT) n_sat++;
        if (out_res_re !== exp_r.re) begin
          $display("%0t: res_re expected %h actual %h", $time, exp_r.re, out_res_re);
          errors++;
        end
        if (out_res_im !== exp_r.im) begin
          $display("%0t: res_im expected %h actual %h", $time, exp_r.im, out_res_im);
          errors++;
        end
        if (out_status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    accepted_now = start && !busy && rst_n;
    if (accepted_now || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = cau_pkg::CMD_ADD;
    in_a_re = 0;
    in_a_im = 0;
    in_b_re = 0;
    in_b_im = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(540, 17);
    test_drain_pause();
    test_random(540, 71);
    test_random(540, 0);
    wait_all_results();
    repeat (LATENCY + 16) @(posedge clk);

    $display("covered %0d transactions, %0d results checked", n_sent, n_checked);
    $display("divide-by-zero results %0d, saturated results %0d", n_dz, n_sat);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
